FILE: hdl/hps_pkg.sv
package hps_pkg;

  // storage and field sizes
  localparam int MaxNeighbors = 16;
  localparam int ResultCap    = 16;
  localparam int KCap         = (MaxNeighbors < ResultCap) ? MaxNeighbors : ResultCap;
  localparam int IdxW         = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
  localparam int PosW         = IdxW + 2;
  localparam int CntW         = $clog2(KCap + 1);
  localparam int NcW          = 5;
  localparam int KeyW         = 32;
  localparam int IdW          = 31;
  localparam int RankW        = 4;

  localparam logic [KeyW-1:0] KeyMax  = {KeyW{1'b1}};
  localparam logic [NcW-1:0]  NcReset = NcW'(16);

  // request opcodes
  localparam logic OpOffer = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } store_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_O_ROOT,
    ST_O_CHK,
    ST_O_RD,
    ST_O_CMP,
    ST_O_DEC,
    ST_O_WR,
    ST_D_SWRD,
    ST_D_SWWR,
    ST_D_RD,
    ST_D_C1,
    ST_D_C2,
    ST_D_WR,
    ST_D_ORD,
    ST_D_OLD
  } state_t;

  typedef enum logic [2:0] {
    CMP_NEW_ROOT,
    CMP_RIGHT_LEFT,
    CMP_NEW_PICK,
    CMP_CUR_LEFT,
    CMP_BIG_RIGHT
  } cmp_sel_t;

  typedef struct packed {
    cmp_sel_t        sel;
    logic [KeyW-1:0] new_key;
    logic [KeyW-1:0] cur_key;
    logic [KeyW-1:0] big_key;
    logic [KeyW-1:0] left_key;
    logic [KeyW-1:0] right_key;
  } cmp_req_t;

endpackage

FILE: hdl/hps_if.sv
interface hps_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [hps_pkg::KeyW-1:0]  cand_distance;
  logic [hps_pkg::IdW-1:0]   cand_index;

  modport source (output valid, opcode, cand_distance, cand_index, input ready);
  modport sink   (input valid, opcode, cand_distance, cand_index, output ready);
endinterface

interface hps_out_if;
  logic                      valid;
  logic                      ready;
  logic [hps_pkg::KeyW-1:0]  out_distance;
  logic [hps_pkg::IdW-1:0]   out_index;
  logic [hps_pkg::RankW-1:0] rank;
  logic                      last;

  modport source (output valid, out_distance, out_index, rank, last, input ready);
  modport sink   (input valid, out_distance, out_index, rank, last, output ready);
endinterface

FILE: hdl/bounded_topk_heap_select.sv
// k-smallest selector over a bounded max-heap of (distance, index) entries.
// in_req carries requests: opcode offer adds a candidate, opcode drain emits
// the kept entries in ascending distance and empties the store. out_rsp
// carries one result per kept entry, rank 0 first, last set on the final one.
// cfg_wr_en/cfg_wr_data set neighbor_count (k, saturated to 1..16); write it
// only while no request is in flight.
// Each request runs to completion before the next is accepted; in_req.ready is high only between requests.
// An offer uses one shared comparator twice per heap level: a root read and
// admission check, then per level a child read, a larger-child compare and a
// compare against the new key, and last a write of the new entry.
// A drain runs k swap-and-sift passes (swap read, swap write, then per level a
// read and two compares, and a write-back), then a read and load per result
// while the receiver keeps up; a stalled out_rsp holds its result and the drain
// waits. An offer may start while the last result is still held.
// Reset sets k to 16 and marks every entry empty (maximum key, index zero)
// at once through per-entry valid bits; a drain clears them the same way.
module bounded_topk_heap_select (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [hps_pkg::NcW-1:0] cfg_wr_data,
  hps_in_if.sink                  in_req,
  hps_out_if.source               out_rsp
);

  logic [hps_pkg::IdxW-1:0] rd_addr_a;
  logic [hps_pkg::IdxW-1:0] rd_addr_b;
  hps_pkg::entry_t          rd_a;
  hps_pkg::entry_t          rd_b;
  hps_pkg::store_wr_t       wr;
  logic                     clear;
  hps_pkg::cmp_req_t        cmp_req;
  logic                     cmp_lt;

  // sequencer with working registers and result register
  hps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_req),
    .out_rsp     (out_rsp),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_a        (rd_a),
    .rd_b        (rd_b),
    .wr          (wr),
    .clear       (clear),
    .cmp_req     (cmp_req),
    .cmp_lt      (cmp_lt)
  );

  // heap entry store
  hps_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .clear     (clear),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // shared key comparator
  hps_cmp u_cmp (
    .req (cmp_req),
    .lt  (cmp_lt)
  );

endmodule

FILE: hdl/hps_ram.sv
module hps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr_a,
  input  logic [AddrW-1:0] raddr_b,
  output logic [Width-1:0] rdata_a,
  output logic [Width-1:0] rdata_b
);

  logic [Width-1:0] mem [Depth];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/hps_store.sv
module hps_store (
  input  logic                     clk,
  input  logic                     rst,
  input  hps_pkg::store_wr_t       wr,
  input  logic                     clear,
  input  logic [hps_pkg::IdxW-1:0] rd_addr_a,
  input  logic [hps_pkg::IdxW-1:0] rd_addr_b,
  output hps_pkg::entry_t          rd_a,
  output hps_pkg::entry_t          rd_b
);

  logic [hps_pkg::MaxNeighbors-1:0] valid;
  logic                             valid_a;
  logic                             valid_b;
  hps_pkg::entry_t                  ram_a;
  hps_pkg::entry_t                  ram_b;
  hps_pkg::entry_t                  empty_entry;

  hps_ram #(
    .Width ($bits(hps_pkg::entry_t)),
    .Depth (hps_pkg::MaxNeighbors)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // per-entry valid bits, cleared by reset and after a drain
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // valid flag follows the registered read
  always_ff @(posedge clk) begin
    valid_a <= valid[rd_addr_a];
    valid_b <= valid[rd_addr_b];
  end

  // unwritten entries read as the empty key
  assign empty_entry = '{key: hps_pkg::KeyMax, id: '0};
  assign rd_a        = valid_a ? ram_a : empty_entry;
  assign rd_b        = valid_b ? ram_b : empty_entry;

endmodule

FILE: hdl/hps_cmp.sv
module hps_cmp (
  input  hps_pkg::cmp_req_t req,
  output logic              lt
);

  logic [hps_pkg::KeyW-1:0] op_a;
  logic [hps_pkg::KeyW-1:0] op_b;

  // operand selection for the shared key comparator
  always_comb begin
    unique case (req.sel)
      hps_pkg::CMP_NEW_ROOT: begin
        op_a = req.new_key;
        op_b = req.left_key;
      end
      hps_pkg::CMP_RIGHT_LEFT: begin
        op_a = req.right_key;
        op_b = req.left_key;
      end
      hps_pkg::CMP_NEW_PICK: begin
        op_a = req.new_key;
        op_b = req.big_key;
      end
      hps_pkg::CMP_CUR_LEFT: begin
        op_a = req.cur_key;
        op_b = req.left_key;
      end
      hps_pkg::CMP_BIG_RIGHT: begin
        op_a = req.big_key;
        op_b = req.right_key;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // unsigned less-than
  assign lt = op_a < op_b;

endmodule

FILE: hdl/hps_seq.sv
module hps_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [hps_pkg::NcW-1:0]  cfg_wr_data,
  hps_in_if.sink                   in_req,
  hps_out_if.source                out_rsp,
  output logic [hps_pkg::IdxW-1:0] rd_addr_a,
  output logic [hps_pkg::IdxW-1:0] rd_addr_b,
  input  hps_pkg::entry_t          rd_a,
  input  hps_pkg::entry_t          rd_b,
  output hps_pkg::store_wr_t       wr,
  output logic                     clear,
  output hps_pkg::cmp_req_t        cmp_req,
  input  logic                     cmp_lt
);

  hps_pkg::state_t state, state_next;

  logic [hps_pkg::NcW-1:0]  neighbor_count;
  logic [hps_pkg::CntW-1:0] k;

  logic [hps_pkg::KeyW-1:0] new_key, new_key_next;
  logic [hps_pkg::IdW-1:0]  new_id, new_id_next;
  logic [hps_pkg::IdxW-1:0] node, node_next;
  logic [hps_pkg::IdxW-1:0] j, j_next;
  logic [hps_pkg::IdxW-1:0] out_i, out_i_next;
  logic [hps_pkg::IdxW-1:0] big_idx, big_idx_next;
  hps_pkg::entry_t          cur, cur_next;
  hps_pkg::entry_t          big, big_next;

  logic [hps_pkg::PosW-1:0] node_ext, lc, rc, k_ext, j_ext;
  logic                     lc_in_k, rc_in_k, lc_in_j, rc_in_j;
  logic [hps_pkg::KeyW-1:0] right_key;
  logic                     take_right, moved;
  logic                     out_free, out_last, out_load;

  // effective k, saturated to 1..cap
  always_comb begin
    priority if (neighbor_count == '0) begin
      k = hps_pkg::CntW'(1);
    end else if (hps_pkg::CntW'(neighbor_count) > hps_pkg::CntW'(hps_pkg::KCap)) begin
      k = hps_pkg::CntW'(hps_pkg::KCap);
    end else begin
      k = hps_pkg::CntW'(neighbor_count);
    end
  end

  // child positions and bounds
  assign node_ext = hps_pkg::PosW'(node);
  assign lc       = {node_ext[hps_pkg::PosW-2:0], 1'b1};
  assign rc       = lc + hps_pkg::PosW'(1);
  assign k_ext    = hps_pkg::PosW'(k);
  assign j_ext    = hps_pkg::PosW'(j);
  assign lc_in_k  = lc < k_ext;
  assign rc_in_k  = rc < k_ext;
  assign lc_in_j  = lc < j_ext;
  assign rc_in_j  = rc < j_ext;

  // a missing right child counts as key zero during an offer
  assign right_key = rc_in_k ? rd_b.key : '0;

  // sift-down decision of the drain
  assign take_right = rc_in_j && cmp_lt;
  assign moved      = take_right || (big_idx != node);

  // result register handshake
  assign out_free = !out_rsp.valid || out_rsp.ready;
  assign out_last = (hps_pkg::CntW'(out_i) + hps_pkg::CntW'(1)) == k;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hps_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          state_next = (in_req.opcode == hps_pkg::OpOffer) ? hps_pkg::ST_O_ROOT
                                                          : hps_pkg::ST_D_SWRD;
        end
      end
      hps_pkg::ST_O_ROOT: state_next = hps_pkg::ST_O_CHK;
      hps_pkg::ST_O_CHK:  state_next = cmp_lt ? hps_pkg::ST_O_RD : hps_pkg::ST_IDLE;
      hps_pkg::ST_O_RD:   state_next = lc_in_k ? hps_pkg::ST_O_CMP : hps_pkg::ST_O_WR;
      hps_pkg::ST_O_CMP:  state_next = hps_pkg::ST_O_DEC;
      hps_pkg::ST_O_DEC:  state_next = cmp_lt ? hps_pkg::ST_O_RD : hps_pkg::ST_O_WR;
      hps_pkg::ST_O_WR:   state_next = hps_pkg::ST_IDLE;
      hps_pkg::ST_D_SWRD: state_next = hps_pkg::ST_D_SWWR;
      hps_pkg::ST_D_SWWR: state_next = hps_pkg::ST_D_RD;
      hps_pkg::ST_D_RD:   state_next = lc_in_j ? hps_pkg::ST_D_C1 : hps_pkg::ST_D_WR;
      hps_pkg::ST_D_C1:   state_next = hps_pkg::ST_D_C2;
      hps_pkg::ST_D_C2:   state_next = moved ? hps_pkg::ST_D_RD : hps_pkg::ST_D_WR;
      hps_pkg::ST_D_WR:   state_next = (j == '0) ? hps_pkg::ST_D_ORD : hps_pkg::ST_D_SWRD;
      hps_pkg::ST_D_ORD:  state_next = hps_pkg::ST_D_OLD;
      hps_pkg::ST_D_OLD: begin
        if (out_free) begin
          state_next = out_last ? hps_pkg::ST_IDLE : hps_pkg::ST_D_ORD;
        end
      end
      default: state_next = hps_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    in_req.ready = (state == hps_pkg::ST_IDLE);
    rd_addr_a    = lc[hps_pkg::IdxW-1:0];
    rd_addr_b    = rc[hps_pkg::IdxW-1:0];
    wr           = '0;
    clear        = 1'b0;
    out_load     = 1'b0;

    cmp_req.sel       = hps_pkg::CMP_NEW_ROOT;
    cmp_req.new_key   = new_key;
    cmp_req.cur_key   = cur.key;
    cmp_req.big_key   = big.key;
    cmp_req.left_key  = rd_a.key;
    cmp_req.right_key = right_key;

    new_key_next = new_key;
    new_id_next  = new_id;
    node_next    = node;
    j_next       = j;
    out_i_next   = out_i;
    big_idx_next = big_idx;
    cur_next     = cur;
    big_next     = big;

    unique case (state)
      hps_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          new_key_next = in_req.cand_distance;
          new_id_next  = in_req.cand_index;
          node_next    = '0;
          j_next       = hps_pkg::IdxW'(k - hps_pkg::CntW'(1));
        end
      end
      // root lookup and admission test
      hps_pkg::ST_O_ROOT: begin
        rd_addr_a = '0;
      end
      hps_pkg::ST_O_CHK: begin
        cmp_req.sel = hps_pkg::CMP_NEW_ROOT;
      end
      hps_pkg::ST_O_RD: begin
      end
      // larger child, ties to the right
      hps_pkg::ST_O_CMP: begin
        cmp_req.sel = hps_pkg::CMP_RIGHT_LEFT;
        if (cmp_lt) begin
          big_next     = rd_a;
          big_idx_next = lc[hps_pkg::IdxW-1:0];
        end else begin
          big_next     = '{key: right_key, id: rd_b.id};
          big_idx_next = rc[hps_pkg::IdxW-1:0];
        end
      end
      // pull the child up while it exceeds the new key
      hps_pkg::ST_O_DEC: begin
        cmp_req.sel = hps_pkg::CMP_NEW_PICK;
        if (cmp_lt) begin
          wr.en     = 1'b1;
          wr.addr   = node;
          wr.data   = big;
          node_next = big_idx;
        end
      end
      hps_pkg::ST_O_WR: begin
        wr.en   = 1'b1;
        wr.addr = node;
        wr.data = '{key: new_key, id: new_id};
      end
      // swap root with the tail of the shrinking heap
      hps_pkg::ST_D_SWRD: begin
        rd_addr_a = '0;
        rd_addr_b = j;
      end
      hps_pkg::ST_D_SWWR: begin
        wr.en     = 1'b1;
        wr.addr   = j;
        wr.data   = rd_a;
        cur_next  = rd_b;
        node_next = '0;
      end
      hps_pkg::ST_D_RD: begin
      end
      // sift the held entry down
      hps_pkg::ST_D_C1: begin
        cmp_req.sel = hps_pkg::CMP_CUR_LEFT;
        if (cmp_lt) begin
          big_next     = rd_a;
          big_idx_next = lc[hps_pkg::IdxW-1:0];
        end else begin
          big_next     = cur;
          big_idx_next = node;
        end
      end
      hps_pkg::ST_D_C2: begin
        cmp_req.sel       = hps_pkg::CMP_BIG_RIGHT;
        cmp_req.right_key = rd_b.key;
        if (moved) begin
          wr.en     = 1'b1;
          wr.addr   = node;
          wr.data   = take_right ? rd_b : big;
          node_next = take_right ? rc[hps_pkg::IdxW-1:0] : big_idx;
        end
      end
      hps_pkg::ST_D_WR: begin
        wr.en   = 1'b1;
        wr.addr = node;
        wr.data = cur;
        if (j == '0) begin
          out_i_next = '0;
        end else begin
          j_next = j - hps_pkg::IdxW'(1);
        end
      end
      // stream the sorted entries out
      hps_pkg::ST_D_ORD: begin
        rd_addr_a = out_i;
      end
      hps_pkg::ST_D_OLD: begin
        rd_addr_a = out_i;
        if (out_free) begin
          out_load = 1'b1;
          if (out_last) begin
            clear = 1'b1;
          end else begin
            out_i_next = out_i + hps_pkg::IdxW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= hps_pkg::ST_IDLE;
      neighbor_count <= hps_pkg::NcReset;
      out_rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        neighbor_count <= cfg_wr_data;
      end
      if (out_load) begin
        out_rsp.valid <= 1'b1;
      end else if (out_rsp.ready) begin
        out_rsp.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    new_key <= new_key_next;
    new_id  <= new_id_next;
    node    <= node_next;
    j       <= j_next;
    out_i   <= out_i_next;
    big_idx <= big_idx_next;
    cur     <= cur_next;
    big     <= big_next;
    if (out_load) begin
      out_rsp.out_distance <= rd_a.key;
      out_rsp.out_index    <= rd_a.id;
      out_rsp.rank         <= hps_pkg::RankW'(out_i);
      out_rsp.last         <= out_last;
    end
  end

endmodule

FILE: tb/sv/hps_topk_check_pkg.sv
package hps_topk_check_pkg;
  import hps_pkg::*;

  // one ranked neighbor as the block should emit it
  typedef struct packed {
    logic [KeyW-1:0]  distance;
    logic [IdW-1:0]   idx;
    logic [RankW-1:0] rank;
    logic             last;
  } ranked_t;

  localparam int ReportCap = 100;

  // mirror of the bounded max-heap plus the queue of ranked neighbors still due
  class heap_select_model;
    logic [KeyW-1:0] keys [MaxNeighbors];
    logic [IdW-1:0]  ids  [MaxNeighbors];
    logic [NcW-1:0]  neighbor_count;
    ranked_t         ranked_due [$];
    int              mismatches;

    function new();
      clear_store();
      neighbor_count = NcReset;
      mismatches = 0;
    endfunction

    function void clear_store();
      for (int i = 0; i < MaxNeighbors; i++) begin
        keys[i] = KeyMax;
        ids[i]  = '0;
      end
    endfunction

    function void set_neighbor_count(logic [NcW-1:0] value);
      neighbor_count = value;
    endfunction

    function int pending();
      return ranked_due.size();
    endfunction

    // k saturated to 1..KCap
    function int active_count();
      int k;
      k = neighbor_count;
      if (k < 1) k = 1;
      if (k > KCap) k = KCap;
      return k;
    endfunction

    function void swap_entries(int a, int b);
      logic [KeyW-1:0] tk;
      logic [IdW-1:0]  ti;
      tk = keys[a]; keys[a] = keys[b]; keys[b] = tk;
      ti = ids[a];  ids[a]  = ids[b];  ids[b]  = ti;
    endfunction

    // replace the root and walk down; ties favor the right side and a missing right child counts as key zero
    function void replace_root(logic [KeyW-1:0] key, logic [IdW-1:0] id, int k);
      int pos, lc, rc, pick;
      logic [KeyW-1:0] pick_key, r_key;
      pos = 0;
      while (1) begin
        lc = pos * 2 + 1;
        if (lc >= k) break;
        rc = lc + 1;
        r_key = (rc >= k) ? '0 : keys[rc];
        if (keys[lc] <= r_key) begin
          pick = rc;
          pick_key = r_key;
        end else begin
          pick = lc;
          pick_key = keys[lc];
        end
        if (pick_key <= key || pick >= k) break;
        keys[pos] = keys[pick];
        ids[pos]  = ids[pick];
        pos = pick;
      end
      keys[pos] = key;
      ids[pos]  = id;
    endfunction

    // heapify from the root over the first size entries
    function void sift_down(int size);
      int node, lc, rc, big;
      node = 0;
      while (node * 2 + 1 < size) begin
        lc = node * 2 + 1;
        rc = lc + 1;
        big = node;
        if (keys[big] < keys[lc]) big = lc;
        if (rc < size && keys[big] < keys[rc]) big = rc;
        if (big == node) break;
        swap_entries(node, big);
        node = big;
      end
    endfunction

    // account for one accepted request
    function void note_request(logic op, logic [KeyW-1:0] distance, logic [IdW-1:0] idx);
      int k;
      ranked_t r;
      k = active_count();
      if (op == OpOffer) begin
        if (distance < keys[0]) replace_root(distance, idx, k);
      end else begin
        for (int i = 1; i <= k; i++) begin
          swap_entries(0, k - i);
          sift_down(k - i);
        end
        for (int i = 0; i < k; i++) begin
          r.distance = keys[i];
          r.idx      = ids[i];
          r.rank     = RankW'(i);
          r.last     = (i + 1 == k);
          ranked_due.push_back(r);
        end
        clear_store();
      end
    endfunction

    function void flag_field(string name, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $error("%s: expected %0h, actual %0h", name, want, got);
      end
    endfunction

    // compare one accepted result with the oldest neighbor due
    function void check_result(logic [KeyW-1:0] distance, logic [IdW-1:0] idx,
                               logic [RankW-1:0] rank, logic last);
      ranked_t want;
      if (ranked_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $error("unexpected result: rank %0d distance %0h index %0h", rank, distance, idx);
        return;
      end
      want = ranked_due.pop_front();
      flag_field("out_distance", want.distance, distance);
      flag_field("out_index", KeyW'(want.idx), KeyW'(idx));
      flag_field("rank", KeyW'(want.rank), KeyW'(rank));
      flag_field("last", KeyW'(want.last), KeyW'(last));
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_bounded_topk_heap_select.sv
module tb_bounded_topk_heap_select;
  timeunit 1ns;
  timeprecision 1ps;

  import hps_pkg::*;
  import hps_topk_check_pkg::*;

  localparam int     ItemTarget     = 170;
  localparam int     MaxGap         = 9;
  localparam int     SettleCycles   = 40;
  localparam int     SinkHoldCycles = 600;
  localparam int     TailCycles     = 50;
  localparam longint TimeoutNs      = 5_000_000;

  logic           clk;
  logic           rst;
  logic           cfg_wr_en;
  logic [NcW-1:0] cfg_wr_data;

  hps_in_if  in_req();
  hps_out_if out_rsp();

  bounded_topk_heap_select u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_req),
    .out_rsp     (out_rsp)
  );

  heap_select_model model = new();

  bit src_idle_en;
  bit snk_idle_en;
  bit hold_req;
  int sent_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("bounded_topk_heap_select verification failed");
    $finish;
  end

  function automatic int draw_gap(bit enable);
    return enable ? $urandom_range(0, MaxGap) : 0;
  endfunction

  // distance mix: full range, tiny keys for ties, near-maximum, float-like
  function automatic logic [KeyW-1:0] rand_distance();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return KeyW'($urandom_range(0, 31));
      2: return KeyMax - KeyW'($urandom_range(0, 3));
      default: return {1'b0, 8'($urandom_range(100, 140)), 23'($urandom())};
    endcase
  endfunction

  // k choices with the extremes and out-of-range values weighted in
  function automatic logic [NcW-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return NcW'(1);
      1: return NcW'(16);
      2: return NcW'(0);
      3: return NcW'($urandom_range(17, 31));
      default: return NcW'($urandom_range(2, 15));
    endcase
  endfunction

  // offer one request and wait for its acceptance
  task automatic push_request(logic op, logic [KeyW-1:0] distance, logic [IdW-1:0] idx);
    int gap;
    gap = draw_gap(src_idle_en);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.opcode        <= op;
    in_req.cand_distance <= distance;
    in_req.cand_index    <= idx;
    do @(posedge clk); while (!in_req.ready);
    model.note_request(op, distance, idx);
    sent_count++;
  endtask

  task automatic offer(logic [KeyW-1:0] distance, logic [IdW-1:0] idx);
    push_request(OpOffer, distance, idx);
  endtask

  task automatic drain();
    push_request(OpDrain, $urandom(), IdW'($urandom()));
  endtask

  // sender pause: all results in, then let a trailing offer finish
  task automatic wait_quiet();
    in_req.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_neighbor_count(logic [NcW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model.set_neighbor_count(value);
  endtask

  // result receiver with random stalls and an occasional long hold-off
  initial begin
    int gap;
    out_rsp.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = draw_gap(snk_idle_en);
      if (gap > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      forever begin
        @(posedge clk);
        if (out_rsp.valid) break;
        if (hold_req) begin
          out_rsp.ready <= 1'b0;
          repeat (SinkHoldCycles) @(posedge clk);
          hold_req = 1'b0;
          out_rsp.ready <= 1'b1;
        end
      end
      model.check_result(out_rsp.out_distance, out_rsp.out_index, out_rsp.rank, out_rsp.last);
    end
  end

  // stimulus
  initial begin
    int n_offers;
    in_req.valid         <= 1'b0;
    in_req.opcode        <= OpOffer;
    in_req.cand_distance <= '0;
    in_req.cand_index    <= '0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= NcReset;
    rst                  <= 1'b1;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    hold_req    = 1'b0;
    sent_count  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store drains as k maximum keys
    drain();
    // maximum key is dropped on an empty store, extremes of both fields
    offer(KeyMax, IdW'(32'h7fff_ffff));
    offer(KeyMax - 1, IdW'(1));
    offer('0, '0);
    // equal keys
    offer(32'h3f80_0000, IdW'(32'h2aaa_aaaa));
    offer(32'h3f80_0000, IdW'(32'h5555_5555));
    offer(32'h3f80_0000, IdW'(7));
    offer(32'h7f7f_ffff, IdW'(3));
    offer(32'h0000_0001, IdW'(4));
    drain();

    // single entry heap, later offer at or above the root is dropped
    wait_quiet();
    write_neighbor_count(NcW'(1));
    offer(32'd5, IdW'(10));
    offer(32'd9, IdW'(11));
    offer(32'd2, IdW'(12));
    drain();

    // zero acts as one
    wait_quiet();
    write_neighbor_count(NcW'(0));
    offer(32'd100, IdW'(20));
    drain();

    // above the cap saturates, then k shrinks with entries left behind
    wait_quiet();
    write_neighbor_count(NcW'(31));
    offer(32'd10, IdW'(30));
    offer(32'd20, IdW'(31));
    offer(32'd30, IdW'(32));
    offer(32'd40, IdW'(33));
    wait_quiet();
    write_neighbor_count(NcW'(3));
    offer(32'd5, IdW'(34));
    offer(32'd25, IdW'(35));
    wait_quiet();
    write_neighbor_count(NcW'(16));
    offer(32'd1, IdW'(36));
    drain();

    // receiver holds off while requests keep coming, so the input stalls
    for (int i = 0; i < 6; i++) offer(rand_distance(), IdW'($urandom()));
    drain();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) offer(rand_distance(), IdW'($urandom()));
    drain();
    wait_quiet();

    // random batches: offers with random content closed by a drain
    while (sent_count < ItemTarget) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        wait_quiet();
        write_neighbor_count(pick_count());
      end
      n_offers = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      for (int i = 0; i < n_offers; i++) offer(rand_distance(), IdW'($urandom()));
      drain();
      if ($urandom_range(0, 4) == 0) wait_quiet();
    end

    // wind down
    in_req.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("bounded_topk_heap_select verification clean");
    end else begin
      $display("bounded_topk_heap_select verification failed");
    end
    $finish;
  end

endmodule
